FILE: src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and the distance-to-gain table of the proximity
// slew dimmer.
// ----------------------------------------------------------------------------
package psd_pkg;

  typedef logic [7:0] dist_t;
  typedef logic [7:0] pixel_t;
  typedef logic [7:0] gain_t;

  // func codes
  typedef enum logic {
    FUNC_FRAME = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  localparam int    NUM_CHANNELS  = 3;
  localparam dist_t NEAR_DISTANCE = 8'd5;
  localparam dist_t FAR_DISTANCE  = 8'd200;
  localparam dist_t SMOOTH_RESET  = 8'd100;
  localparam int    GAIN_NEAR     = 255;
  localparam int    GAIN_FAR      = 20;
  localparam int    GAIN_SPAN     = int'(FAR_DISTANCE) - int'(NEAR_DISTANCE);

  typedef gain_t gain_table_t [0:255];

  // Gain for every smoothed distance; evaluated at elaboration.
  // Signed division truncates toward zero, then clamp to GAIN_FAR..GAIN_NEAR.
  function automatic gain_table_t build_gain_table();
    gain_table_t tbl;
    int          num;
    int          g;
    for (int d = 0; d < 256; d++) begin
      num = (d - int'(NEAR_DISTANCE)) * (GAIN_FAR - GAIN_NEAR);
      g   = GAIN_NEAR + num / GAIN_SPAN;
      if (g < GAIN_FAR) g = GAIN_FAR;
      if (g > GAIN_NEAR) g = GAIN_NEAR;
      tbl[d] = gain_t'(g);
    end
    return tbl;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();
  localparam gain_t       GAIN_RESET = GAIN_TABLE[SMOOTH_RESET];

endpackage

FILE: src/psd_channel.sv
// ----------------------------------------------------------------------------
// psd_channel
// One color channel: slewed distance, its gain, and the pixel scaler.
// ----------------------------------------------------------------------------
module psd_channel (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,      // frame beat leaves the input register
  input  psd_pkg::dist_t dist_in,
  input  psd_pkg::pixel_t color,
  output psd_pkg::pixel_t scaled
);

  psd_pkg::dist_t reading;
  psd_pkg::dist_t smooth;
  psd_pkg::dist_t smooth_next;
  psd_pkg::gain_t gain;
  logic [15:0]    product;
  logic [15:0]    rounded;

  // clamp reading to near..far
  always_comb begin
    if (dist_in < psd_pkg::NEAR_DISTANCE) begin
      reading = psd_pkg::NEAR_DISTANCE;
    end else if (dist_in > psd_pkg::FAR_DISTANCE) begin
      reading = psd_pkg::FAR_DISTANCE;
    end else begin
      reading = dist_in;
    end
  end

  // one step toward the reading
  always_comb begin
    if (reading < smooth) begin
      smooth_next = smooth - 8'd1;
    end else if (reading > smooth) begin
      smooth_next = smooth + 8'd1;
    end else begin
      smooth_next = smooth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth <= psd_pkg::SMOOTH_RESET;
      gain   <= psd_pkg::GAIN_RESET;
    end else if (step) begin
      smooth <= smooth_next;
      gain   <= psd_pkg::GAIN_TABLE[smooth_next];
    end
  end

  // floor(p / 255) = (p + (p >> 8) + 1) >> 8 for p <= 255 * 255
  assign product = {8'd0, gain} * {8'd0, color};
  assign rounded = product + {8'd0, product[15:8]} + 16'd1;
  assign scaled  = rounded[15:8];

  // ---- assertions ----
  a_slew_one_step: assert property (@(posedge clk) disable iff (rst)
    smooth == $past(smooth) || smooth == $past(smooth) + 8'd1 ||
    smooth == $past(smooth) - 8'd1)
    else $error("smoothed distance moved more than one step");

  a_gain_tracks: assert property (@(posedge clk) disable iff (rst)
    gain == psd_pkg::GAIN_TABLE[smooth])
    else $error("gain out of step with smoothed distance");

endmodule

FILE: src/proximity_slew_dimmer.sv
// ----------------------------------------------------------------------------
// proximity_slew_dimmer
// Per-color dimmer whose gains follow three slewed distance readings.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall is low. A frame beat (func 0)
// moves each channel's smoothed distance one step toward its clamped
// reading and reloads that channel's gain from a constant table; it yields
// no result. A pixel beat (func 1) returns each color times its channel's
// gain divided by 255, truncated. A pixel's result passes through one input
// register, then the scaler (one 8x8 multiply per channel plus a reciprocal
// fix-up for /255) into the result register. A pixel that follows a frame
// beat in the next cycle already sees the new gains. The result register
// and the input register are separate, so a new beat is taken while a
// finished result waits on out_stall; in_stall rises only when both hold a
// pixel and the result is stalled. Gains after reset correspond to a
// smoothed distance of 100.
// ----------------------------------------------------------------------------
module proximity_slew_dimmer (
  input  logic            clk,
  input  logic            rst,
  // input channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            func,
  input  psd_pkg::dist_t  dist_a,
  input  psd_pkg::dist_t  dist_b,
  input  psd_pkg::dist_t  dist_c,
  input  psd_pkg::pixel_t red_in,
  input  psd_pkg::pixel_t green_in,
  input  psd_pkg::pixel_t blue_in,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output psd_pkg::pixel_t red_out,
  output psd_pkg::pixel_t green_out,
  output psd_pkg::pixel_t blue_out
);

  // input register
  logic            s1_valid;
  psd_pkg::func_t  s1_func;
  psd_pkg::dist_t  s1_dist  [psd_pkg::NUM_CHANNELS];
  psd_pkg::pixel_t s1_color [psd_pkg::NUM_CHANNELS];

  logic            in_accept;
  logic            out_free;     // result register can take a new beat
  logic            s1_advance;
  logic            frame_step;
  logic            pixel_fire;
  psd_pkg::pixel_t scaled [psd_pkg::NUM_CHANNELS];

  assign out_free   = !out_valid || !out_stall;
  // frame beats never wait; pixel beats wait on the result register
  assign s1_advance = s1_valid && (s1_func == psd_pkg::FUNC_FRAME || out_free);
  assign frame_step = s1_valid && s1_func == psd_pkg::FUNC_FRAME;
  assign pixel_fire = s1_valid && s1_func == psd_pkg::FUNC_PIXEL && out_free;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func     <= psd_pkg::func_t'(func);
      s1_dist[0]  <= dist_a;
      s1_dist[1]  <= dist_b;
      s1_dist[2]  <= dist_c;
      s1_color[0] <= red_in;
      s1_color[1] <= green_in;
      s1_color[2] <= blue_in;
    end
  end

  // one slew/gain/scale unit per color
  for (genvar ch = 0; ch < psd_pkg::NUM_CHANNELS; ch++) begin : g_ch
    psd_channel u_channel (
      .clk     (clk),
      .rst     (rst),
      .step    (frame_step),
      .dist_in (s1_dist[ch]),
      .color   (s1_color[ch]),
      .scaled  (scaled[ch])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pixel_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      red_out   <= scaled[0];
      green_out <= scaled[1];
      blue_out  <= scaled[2];
    end
  end

  // ---- assertions ----
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_func == psd_pkg::FUNC_PIXEL && out_valid && out_stall)
    else $error("input stalled without a blocked pixel");

  a_frame_drains: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_func == psd_pkg::FUNC_FRAME |=> !s1_valid || $past(in_accept))
    else $error("frame beat held in input register");

  a_result_from_pixel: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_func == psd_pkg::FUNC_PIXEL))
    else $error("result raised without a pixel beat");

endmodule
